/* rtl/core/rhsv_pkg.sv */
// Shared types and constants for the 8-bit RGB to HSV converter.
// Used by the front stage, the divider cells, the result stage and the top level.
// No dependencies.
package rhsv_pkg;

  // Number of quotient bits, one per divider cell.
  localparam int unsigned QUO_W     = 8;
  localparam int unsigned NUM_CELLS = QUO_W;

  // Hue bases for the largest channel.
  localparam logic [7:0] HUE_BASE_RED   = 8'd0;
  localparam logic [7:0] HUE_BASE_GREEN = 8'd85;
  localparam logic [7:0] HUE_BASE_BLUE  = 8'd171;

  // One long-division lane: partial remainder, numerator bits not yet
  // consumed (most significant first), divisor and quotient so far.
  typedef struct packed {
    logic [7:0]       rem;
    logic [7:0]       num;
    logic [7:0]       den;
    logic [QUO_W-1:0] quo;
  } lane_t;

  // Side information that travels with the item through the cells.
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] base;
    logic       neg;
    logic       grey;
  } side_t;

  // Everything one cell holds for one item.
  typedef struct packed {
    lane_t sat;
    lane_t hue;
    side_t side;
  } cell_t;

endpackage

/* rtl/core/rhsv_prep.sv */
// Front stage of the RGB to HSV converter: max, min, hue sector and numerators.
// Depends on rhsv_pkg.
module rhsv_prep (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  logic [7:0]     red,
  input  logic [7:0]     green,
  input  logic [7:0]     blue,
  output logic           out_valid,
  output rhsv_pkg::cell_t out_data
);
  import rhsv_pkg::*;

  logic        valid_r;
  cell_t       data_r;
  cell_t       data_nxt;
  logic [7:0]  mx;
  logic [7:0]  mn;
  logic [7:0]  delta;
  logic [7:0]  p;
  logic [7:0]  q;
  logic [7:0]  base;
  logic [7:0]  diff;
  logic [15:0] diff_w;
  logic [15:0] delta_w;
  logic [15:0] sat_num;
  logic [15:0] hue_num;

  // Largest and smallest channel.
  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;
  end

  // Hue sector: ties go to red first, then green.
  always_comb begin
    if (mx == red) begin
      base = HUE_BASE_RED;
      p    = green;
      q    = blue;
    end else if (mx == green) begin
      base = HUE_BASE_GREEN;
      p    = blue;
      q    = red;
    end else begin
      base = HUE_BASE_BLUE;
      p    = red;
      q    = green;
    end
    diff = (p >= q) ? (p - q) : (q - p);
  end

  // Numerators: 255 * delta and 43 * |p - q|, both by shifts and adds.
  always_comb begin
    diff_w  = {8'd0, diff};
    delta_w = {8'd0, delta};
    sat_num = (delta_w << 8) - delta_w;
    hue_num = (diff_w << 5) + (diff_w << 3) + (diff_w << 1) + diff_w;

    data_nxt.sat.rem    = sat_num[15:8];
    data_nxt.sat.num    = sat_num[7:0];
    data_nxt.sat.den    = mx;
    data_nxt.sat.quo    = '0;
    data_nxt.hue.rem    = hue_num[15:8];
    data_nxt.hue.num    = hue_num[7:0];
    data_nxt.hue.den    = delta;
    data_nxt.hue.quo    = '0;
    data_nxt.side.value = mx;
    data_nxt.side.base  = base;
    data_nxt.side.neg   = (p < q);
    data_nxt.side.grey  = (delta == 8'd0);
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* rtl/core/rhsv_cell.sv */
// One divider cell: produces one quotient bit for the saturation and hue lanes.
// Depends on rhsv_pkg.
module rhsv_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  rhsv_pkg::cell_t in_data,
  output logic            out_valid,
  output rhsv_pkg::cell_t out_data
);
  import rhsv_pkg::*;

  logic  valid_r;
  cell_t data_r;
  cell_t data_nxt;

  // One restoring long-division step on a lane.
  function automatic lane_t lane_step(input lane_t l);
    lane_t      res;
    logic [8:0] trial;
    logic [8:0] diff;
    logic       ge;
    trial   = {l.rem, l.num[7]};
    diff    = trial - {1'b0, l.den};
    ge      = (trial >= {1'b0, l.den});
    res.rem = ge ? diff[7:0] : trial[7:0];
    res.num = {l.num[6:0], 1'b0};
    res.den = l.den;
    res.quo = {l.quo[QUO_W-2:0], ge};
    return res;
  endfunction

  // Both lanes step together; side information passes on.
  always_comb begin
    data_nxt.sat  = lane_step(in_data.sat);
    data_nxt.hue  = lane_step(in_data.hue);
    data_nxt.side = in_data.side;
  end

  // Cell register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* rtl/core/rhsv_post.sv */
// Result stage: applies the hue sign and base, the grey override, and
// holds the output item. Depends on rhsv_pkg.
module rhsv_post (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  rhsv_pkg::cell_t in_data,
  output logic            out_valid,
  output logic [7:0]      hue,
  output logic [7:0]      saturation,
  output logic [7:0]      value
);
  import rhsv_pkg::*;

  logic       valid_r;
  logic [7:0] hue_r;
  logic [7:0] sat_r;
  logic [7:0] value_r;
  logic [7:0] hue_nxt;
  logic [7:0] sat_nxt;
  logic [7:0] offset;

  // Signed offset added to the sector base, wrapping modulo 256.
  always_comb begin
    offset  = in_data.side.neg ? (8'd0 - in_data.hue.quo) : in_data.hue.quo;
    hue_nxt = in_data.side.grey ? 8'd0 : (in_data.side.base + offset);
    sat_nxt = in_data.side.grey ? 8'd0 : in_data.sat.quo;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      value_r <= in_data.side.value;
    end
  end

  assign out_valid  = valid_r;
  assign hue        = hue_r;
  assign saturation = sat_r;
  assign value      = value_r;

endmodule

/* rtl/core/rgb_to_hsv_8bit_unit.sv */
// RGB to HSV converter for 8-bit pixels: top level with the stream ports.
// Depends on rhsv_pkg, rhsv_prep, rhsv_cell and rhsv_post.
//
// Accepts one pixel per clock and returns one HSV item per pixel, in order.
// From input accept to output valid, an item passes through one front stage
// (max, min, hue sector and numerators), a chain of 8 divider cells that
// each produce one quotient bit of saturation and of hue offset, and one
// output register. The whole chain advances together whenever the output
// register is empty or being taken, so a stall on the output holds every
// stage and throughput is one item per cycle otherwise.
module rgb_to_hsv_8bit_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // hue [7:0], saturation [15:8], value [23:16]
);
  import rhsv_pkg::*;

  logic                  adv;
  logic [NUM_CELLS:0]    chain_valid;
  cell_t [NUM_CELLS:0]   chain_data;
  logic [7:0]            hue;
  logic [7:0]            saturation;
  logic [7:0]            value;

  // The chain moves when the output register can take a new item.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Front stage.
  rhsv_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .red       (in_tdata[7:0]),
    .green     (in_tdata[15:8]),
    .blue      (in_tdata[23:16]),
    .out_valid (chain_valid[0]),
    .out_data  (chain_data[0])
  );

  // Chain of divider cells.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rhsv_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (chain_valid[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  // Result stage and output register.
  rhsv_post u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (chain_valid[NUM_CELLS]),
    .in_data    (chain_data[NUM_CELLS]),
    .out_valid  (out_tvalid),
    .hue        (hue),
    .saturation (saturation),
    .value      (value)
  );

  assign out_tdata = {value, saturation, hue};

`ifndef SYNTH
  // A grey or black pixel has no hue.
  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[15:8] == 8'd0)) |-> (out_tdata[7:0] == 8'd0))
    else $error("hue nonzero with zero saturation");

  // A black pixel has no saturation.
  a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[23:16] == 8'd0)) |-> (out_tdata[15:8] == 8'd0))
    else $error("saturation nonzero with zero value");

  // The hue offset quotient never exceeds 43, about a sixth of the circle.
  a_hue_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (chain_valid[NUM_CELLS] && !chain_data[NUM_CELLS].side.grey)
      |-> (chain_data[NUM_CELLS].hue.quo <= 8'd43))
    else $error("hue offset out of range");
`endif

endmodule

/* test/testbench.sv */
// Self-checking testbench for rgb_to_hsv_8bit_unit, the 8-bit RGB to HSV converter.
// A scoreboard class predicts hue, saturation and value for every accepted pixel.
// It needs only the RTL under rtl/core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // One HSV result, hue in the lowest byte as on out_tdata.
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] saturation;
    logic [7:0] hue;
  } hsv_t;

  // An accepted pixel and the result it must produce.
  typedef struct {
    logic [23:0] rgb;
    hsv_t        hsv;
  } pixel_rec_t;

  // Holds the expected conversions in order of acceptance and checks each result.
  class hsv_scoreboard;
    pixel_rec_t  hsv_expected[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Integer conversion of one pixel, hue wrapping modulo 256.
    function hsv_t predict_hsv(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      int unsigned r, g, b, hi, lo, delta, sat, base, p, q, quot, hue;
      hsv_t res;
      r = 32'(red);
      g = 32'(green);
      b = 32'(blue);
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      delta = hi - lo;
      res = '0;
      res.value = hi[7:0];
      if (hi != 0) begin
        sat = (255 * delta) / hi;
        res.saturation = sat[7:0];
        if (sat != 0) begin
          // Ties go to red, then green.
          if (hi == r) begin
            base = 0;   p = g; q = b;
          end else if (hi == g) begin
            base = 85;  p = b; q = r;
          end else begin
            base = 171; p = r; q = g;
          end
          // Offset truncates toward zero, so divide the magnitude first.
          if (p >= q) begin
            quot = (43 * (p - q)) / delta;
            hue = base + quot;
          end else begin
            quot = (43 * (q - p)) / delta;
            hue = base - quot;
          end
          res.hue = hue[7:0];
        end
      end
      return res;
    endfunction

    function void note_pixel(logic [23:0] rgb);
      pixel_rec_t rec;
      rec.rgb = rgb;
      rec.hsv = predict_hsv(rgb[7:0], rgb[15:8], rgb[23:16]);
      hsv_expected.push_back(rec);
    endfunction

    function int unsigned pending();
      return hsv_expected.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [23:0] data);
      pixel_rec_t rec;
      hsv_t got;
      got = data;
      if (hsv_expected.size() == 0) begin
        report($sformatf("unexpected item %h with nothing pending", data));
      end else begin
        rec = hsv_expected.pop_front();
        if (got.hue !== rec.hsv.hue)
          report($sformatf("rgb %h: hue %0d, expected %0d", rec.rgb, got.hue, rec.hsv.hue));
        if (got.saturation !== rec.hsv.saturation)
          report($sformatf("rgb %h: saturation %0d, expected %0d", rec.rgb,
                           got.saturation, rec.hsv.saturation));
        if (got.value !== rec.hsv.value)
          report($sformatf("rgb %h: value %0d, expected %0d", rec.rgb, got.value,
                           rec.hsv.value));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // hue [7:0], saturation [15:8], value [23:16]

  hsv_scoreboard sb = new();
  int unsigned   cycle_count = 0;
  bit            tx_idle_en = 1'b1;
  bit            rx_idle_en = 1'b1;
  int unsigned   hold_len = 0;
  int unsigned   stall_left = 0;

  rgb_to_hsv_8bit_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned rand_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Random pixel, biased toward greys, ties and tiny channels now and then.
  function automatic logic [23:0] rand_pixel();
    logic [7:0] r, g, b;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    r = 8'($urandom_range(0, 255));
    g = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    case (mode)
      0: begin
        g = r;
        b = r;
      end
      1: begin
        if ($urandom_range(0, 1)) g = r;
        else b = g;
      end
      2: begin
        r = 8'($urandom_range(0, 3));
        g = 8'($urandom_range(0, 3));
        b = 8'($urandom_range(0, 3));
      end
      default: ;
    endcase
    return {b, g, r};
  endfunction

  // Offers one pixel and waits until it is accepted, then idles a while.
  task send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned gap;
    in_tdata = {b, g, r};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    gap = tx_idle_en ? rand_gap() : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task send_random(int unsigned count);
    logic [23:0] px;
    repeat (count) begin
      px = rand_pixel();
      send_pixel(px[7:0], px[15:8], px[23:16]);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_tready = 1'b0;
        hold_len--;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (!rx_idle_en || $urandom_range(0, 99) < 70) begin
        out_tready = 1'b1;
      end else begin
        out_tready = 1'b0;
        stall_left = rand_gap();
      end
    end
  end

  // Both handshakes are sampled at the rising edge; inputs are noted first.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_pixel(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n = 1'b0;
    @(negedge clk);
    rst_n = 1'b1;

    // Directed pixels: black, greys, primaries, ties, hue wrap, tiny deltas.
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd43);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd2,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd2);
    send_pixel(8'd1,   8'd0,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd0);
    send_pixel(8'd254, 8'd255, 8'd253);
    send_pixel(8'd10,  8'd20,  8'd30);
    send_pixel(8'd30,  8'd10,  8'd20);
    send_pixel(8'd170, 8'd85,  8'd85);
    send_pixel(8'd85,  8'd170, 8'd255);

    // Random pixels with idling on both sides.
    send_random(900);

    // Full throughput, no idling anywhere.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random(300);

    // Long receiver hold-off while the sender keeps offering.
    hold_len = 300;
    send_random(100);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    send_random(550);

    // The last pixel has already been taken.
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
